/* rtl/core/alu16_pkg.sv */
// Shared types, action codes and the divider step function for the 16-bit ALU.
package alu16_pkg;

    localparam int WORD_W             = 16;
    localparam int ACTION_W           = 4;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = WORD_W / DIV_BITS_PER_STAGE;

    localparam logic [WORD_W-1:0] WORD_ONES = 16'hFFFF;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ADD = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_SUB = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_MUL = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_DIV = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_AND = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_OR  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_XOR = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_NOT = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_SHL = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_SHR = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_CMP = 4'd10;

    // One input item.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   operand_a;
        logic [WORD_W-1:0]   operand_b;
    } alu16_in_t;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0] result_word;
        logic              zero_flag;
        logic              negative_flag;
        logic              carry_flag;
        logic              overflow_flag;
    } alu16_out_t;

    // Item as it travels down the pipeline, with the divider's working state.
    typedef struct packed {
        logic              is_div;
        logic              div_zero;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] zn_word;
        logic              zn_en;
        logic              c;
        logic              v;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] den;
    } alu16_pipe_t;

    // Advances a restoring division by DIV_BITS_PER_STAGE quotient bits.
    function automatic alu16_pipe_t alu16_div_step(alu16_pipe_t p);
        alu16_pipe_t     q;
        logic [WORD_W:0] trial;
        q = p;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            trial = {q.rem, q.quo[WORD_W-1]};
            q.quo = {q.quo[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, q.den})
            begin
                trial    = trial - {1'b0, q.den};
                q.quo[0] = 1'b1;
            end
            q.rem = trial[WORD_W-1:0];
        end
        return q;
    endfunction

endpackage

/* rtl/core/alu16_with_flags_top.sv */
// Top level of the pipelined 16-bit ALU with Z, N, C and V flags.

// The ALU accepts one item per clock cycle while the output is not stalled and
// returns one result item per item, in order. The pipeline holds eleven register
// stages: an input register, an execute stage (add, subtract, multiply, logic,
// shifts), eight divider stages that each resolve two quotient bits, and the
// output register where the flags are formed. Each stage holds its item until the
// next stage can take it, so empty stages are filled while a result waits at the
// output and a stall neither drops nor repeats items.
module alu16_with_flags_top
    import alu16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  alu16_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output alu16_out_t out_data
);

    logic                  in_vld_reg;
    alu16_in_t             in_reg;
    logic                  ex_vld_reg;
    alu16_pipe_t           ex_reg;
    alu16_pipe_t           ex_next;
    logic [DIV_STAGES-1:0] dv_vld_reg;
    logic [DIV_STAGES-1:0] dv_vld_next;
    alu16_pipe_t           dv_reg  [DIV_STAGES];
    alu16_pipe_t           dv_next [DIV_STAGES];
    logic                  out_vld_reg;
    alu16_out_t            out_reg;
    alu16_out_t            out_next;

    logic                  in_rdy;
    logic                  ex_rdy;
    logic [DIV_STAGES-1:0] dv_rdy;
    logic                  out_rdy;

    // Stage readiness: a stage loads when it is empty or its item moves on.
    always_comb
    begin
        out_rdy = !out_vld_reg || out_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            if (k == DIV_STAGES - 1)
            begin
                dv_rdy[k] = !dv_vld_reg[k] || out_rdy;
            end
            else
            begin
                dv_rdy[k] = !dv_vld_reg[k] || dv_rdy[k+1];
            end
        end
        ex_rdy = !ex_vld_reg || dv_rdy[0];
        in_rdy = !in_vld_reg || ex_rdy;
    end

    assign in_ready  = in_rdy;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Execute stage: every action except divide, which only sets up its operands.
    always_comb
    begin
        logic [WORD_W:0]     sum;
        logic [WORD_W:0]     diff;
        logic [2*WORD_W-1:0] prod;
        logic [2*WORD_W-1:0] shl_w;
        logic [2*WORD_W-1:0] shr_w;
        logic                shift_far;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;

        a         = in_reg.operand_a;
        b         = in_reg.operand_b;
        sum       = {1'b0, a} + {1'b0, b};
        diff      = {1'b0, a} - {1'b0, b};
        prod      = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        shift_far = |b[WORD_W-1:5];
        shl_w     = {{WORD_W{1'b0}}, a} << b[4:0];
        shr_w     = {a, {WORD_W{1'b0}}} >> b[4:0];

        ex_next          = '0;
        ex_next.zn_en    = 1'b1;
        ex_next.rem      = '0;
        ex_next.quo      = a;
        ex_next.den      = b;
        ex_next.div_zero = (b == '0);

        case (in_reg.action)
            ACT_ADD:
            begin
                ex_next.word = sum[WORD_W-1:0];
                ex_next.c    = sum[WORD_W];
                ex_next.v    = !(a[WORD_W-1] ^ b[WORD_W-1])
                               && (a[WORD_W-1] ^ sum[WORD_W-1]);
            end
            ACT_SUB, ACT_CMP:
            begin
                ex_next.word = diff[WORD_W-1:0];
                ex_next.c    = diff[WORD_W];
                ex_next.v    = (a[WORD_W-1] ^ b[WORD_W-1])
                               && (a[WORD_W-1] ^ diff[WORD_W-1]);
            end
            ACT_MUL:
            begin
                ex_next.word = prod[WORD_W-1:0];
                ex_next.c    = |prod[2*WORD_W-1:WORD_W];
            end
            ACT_DIV:
            begin
                ex_next.is_div = 1'b1;
            end
            ACT_AND:
            begin
                ex_next.word = a & b;
            end
            ACT_OR:
            begin
                ex_next.word = a | b;
            end
            ACT_XOR:
            begin
                ex_next.word = a ^ b;
            end
            ACT_NOT:
            begin
                ex_next.word = ~a;
            end
            ACT_SHL:
            begin
                ex_next.word = shift_far ? '0 : shl_w[WORD_W-1:0];
                ex_next.c    = !shift_far && shl_w[WORD_W];
            end
            ACT_SHR:
            begin
                ex_next.word = shift_far ? '0 : shr_w[2*WORD_W-1:WORD_W];
                ex_next.c    = !shift_far && shr_w[WORD_W-1];
            end
            default:
            begin
                ex_next.zn_en = 1'b0;
            end
        endcase

        // Z and N follow the word computed here; compare then reports zero.
        ex_next.zn_word = ex_next.word;
        if (in_reg.action == ACT_CMP)
        begin
            ex_next.word = '0;
        end
    end

    // Divider stages: each advances the quotient by two bits.
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                dv_vld_next[k] = ex_vld_reg;
                dv_next[k]     = alu16_div_step(ex_reg);
            end
            else
            begin
                dv_vld_next[k] = dv_vld_reg[k-1];
                dv_next[k]     = alu16_div_step(dv_reg[k-1]);
            end
        end
    end

    // Output stage: choose the divide result and form the Z and N flags.
    always_comb
    begin
        alu16_pipe_t p;
        p = dv_reg[DIV_STAGES-1];
        if (p.is_div)
        begin
            p.word    = p.div_zero ? WORD_ONES : p.quo;
            p.zn_word = p.word;
            p.zn_en   = !p.div_zero;
            p.c       = 1'b0;
            p.v       = p.div_zero;
        end
        out_next.result_word   = p.word;
        out_next.zero_flag     = p.zn_en && (p.zn_word == '0);
        out_next.negative_flag = p.zn_en && p.zn_word[WORD_W-1];
        out_next.carry_flag    = p.c;
        out_next.overflow_flag = p.v;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            ex_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_rdy)
            begin
                in_vld_reg <= in_valid;
            end
            if (ex_rdy)
            begin
                ex_vld_reg <= in_vld_reg;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (dv_rdy[k])
                begin
                    dv_vld_reg[k] <= dv_vld_next[k];
                end
            end
            if (out_rdy)
            begin
                out_vld_reg <= dv_vld_reg[DIV_STAGES-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            in_reg <= in_data;
        end
        if (ex_rdy)
        begin
            ex_reg <= ex_next;
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (dv_rdy[k])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (out_rdy)
        begin
            out_reg <= out_next;
        end
    end

endmodule
